/* design/als_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants, controller states and the command and status
// types of the anti-aliased line stepper. No dependencies.
package als_pkg;

  localparam int CINT_W   = 9;
  localparam int CFRAC_W  = 8;
  localparam int SFRAC_W  = 16;
  localparam int COVER_W  = 8;
  localparam int COORD_W  = CINT_W + CFRAC_W;
  localparam int ACC_W    = CINT_W + SFRAC_W;
  localparam int SLOPE_W  = SFRAC_W + 2;
  localparam int GAP_W    = CFRAC_W + 1;
  localparam int DIFF_W   = CFRAC_W + 2;
  localparam int PROD_W   = SLOPE_W + DIFF_W;
  localparam int SUM_W    = ACC_W + 2;
  localparam int COLOUR_W = 16;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_FIELD_W = 4 * CINT_W + 2 * COVER_W + COLOUR_W;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int DIV_STEPS = SFRAC_W + 1;
  localparam int CNT_W     = 5;

  localparam logic [CINT_W-1:0]  PIX_MAX   = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
  localparam logic [COVER_W-1:0] COVER_MAX = '1;
  localparam logic [GAP_W-1:0]   GAP_ONE   = GAP_W'(1 << CFRAC_W);
  localparam logic [COORD_W:0]   HALF      = (COORD_W + 1)'(1 << (CFRAC_W - 1));

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWAP,
    ST_ORDER,
    ST_DINIT,
    ST_DIV,
    ST_SLOPE,
    ST_E1_MUL,
    ST_E1_ADD,
    ST_E2_MUL,
    ST_E2_ADD,
    ST_EMIT
  } als_state_t;

  typedef struct packed {
    logic load_in;
    logic swap_axes;
    logic order_ends;
    logic div_init;
    logic div_step;
    logic div_fin;
    logic end_mul;
    logic end_add;
    logic end_sel;
    logic emit_first;
    logic emit_step;
  } als_cmd_t;

  typedef struct packed {
    logic active;
  } als_stat_t;

endpackage

/* design/als_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the line stepper: endpoint setup, serial gradient divider,
// endpoint multiply, column accumulator and the output pixel-pair register.
// Depends on als_pkg.
module als_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  als_pkg::als_cmd_t                    cmd,
  output als_pkg::als_stat_t                   stat,
  input  logic [als_pkg::COORD_W-1:0]          in_start_x,
  input  logic [als_pkg::COORD_W-1:0]          in_start_y,
  input  logic [als_pkg::COORD_W-1:0]          in_end_x,
  input  logic [als_pkg::COORD_W-1:0]          in_end_y,
  input  logic [als_pkg::COLOUR_W-1:0]         in_colour,
  output logic [als_pkg::OUT_TDATA_W-1:0]      out_data,
  output logic                                 out_last
);
  import als_pkg::*;

  logic [COORD_W-1:0]        a0, b0, a1, b1;
  logic                      steep;
  logic [COLOUR_W-1:0]       held_colour;
  logic [COORD_W-1:0]        dvsr;
  logic [COORD_W:0]          rem;
  logic [COORD_W-1:0]        quo;
  logic                      neg;
  logic signed [SLOPE_W-1:0] slope;
  logic signed [PROD_W-1:0]  prod;
  logic [CINT_W-1:0]         column_now, column_last;
  logic [GAP_W-1:0]          first_gap, end_gap;
  logic [ACC_W-1:0]          minor_accum, end_minor;
  logic                      active;

  logic [COORD_W-1:0]        adx, ady, ord_dx, ord_dy;
  logic                      steep_next, ord_neg;
  logic                      rem_ge;
  logic [COORD_W:0]          rem_sub;
  logic [COORD_W-1:0]        e_major, e_minor;
  logic [COORD_W:0]          rsum;
  logic [CINT_W:0]           rcol_raw;
  logic [CINT_W-1:0]         rcol;
  logic [GAP_W-1:0]          rgap;
  logic signed [COORD_W:0]   diff_full;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_next, prod_sh;
  logic signed [SUM_W-1:0]   end_sum, acc_sum;
  logic [ACC_W-1:0]          end_sat, acc_sat;
  logic [CINT_W:0]           col_inc;
  logic                      step_inner;
  logic [CINT_W-1:0]         e_col, pix, pix2;
  logic [ACC_W-1:0]          e_acc;
  logic [GAP_W-1:0]          e_gap;
  logic                      e_last;
  logic [SFRAC_W+COVER_W-1:0] far_wide;
  logic [COVER_W-1:0]        farb, nearb, nc, fc;
  logic [COVER_W+GAP_W-1:0]  nc_prod, fc_prod;
  logic [CINT_W-1:0]         near_x, near_y, far_x, far_y;

  function automatic logic [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic [ACC_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, ACC_MAX})) begin
      r = ACC_MAX;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    adx        = (a1 >= a0) ? a1 - a0 : a0 - a1;
    ady        = (b1 >= b0) ? b1 - b0 : b0 - b1;
    steep_next = ady > adx;
    ord_dx     = a1 - a0;
    ord_neg    = b0 > b1;
    ord_dy     = ord_neg ? b0 - b1 : b1 - b0;

    rem_ge  = rem >= {1'b0, dvsr};
    rem_sub = rem_ge ? rem - {1'b0, dvsr} : rem;

    e_major   = cmd.end_sel ? a1 : a0;
    e_minor   = cmd.end_sel ? b1 : b0;
    rsum      = {1'b0, e_major} + HALF;
    rcol_raw  = rsum[COORD_W:CFRAC_W];
    rcol      = rcol_raw[CINT_W] ? PIX_MAX : rcol_raw[CINT_W-1:0];
    rgap      = GAP_ONE - {1'b0, rsum[CFRAC_W-1:0]};
    diff_full = $signed({1'b0, rcol, {CFRAC_W{1'b0}}}) - $signed({1'b0, e_major});
    diff      = diff_full[DIFF_W-1:0];
    prod_next = slope * diff;
    prod_sh   = prod >>> CFRAC_W;
    end_sum   = $signed({2'b00, e_minor, {(SFRAC_W-CFRAC_W){1'b0}}})
              + $signed(prod_sh[SUM_W-1:0]);
    end_sat   = sat_acc(end_sum);
    acc_sum   = $signed({2'b00, minor_accum})
              + $signed({{(SUM_W-SLOPE_W){slope[SLOPE_W-1]}}, slope});
    acc_sat   = sat_acc(acc_sum);

    col_inc    = {1'b0, column_now} + (CINT_W + 1)'(1);
    step_inner = col_inc < {1'b0, column_last};

    if (cmd.emit_first) begin
      e_col  = column_now;
      e_acc  = minor_accum;
      e_gap  = first_gap;
      e_last = 1'b0;
    end else if (step_inner) begin
      e_col  = col_inc[CINT_W-1:0];
      e_acc  = minor_accum;
      e_gap  = GAP_ONE;
      e_last = 1'b0;
    end else begin
      e_col  = column_last;
      e_acc  = end_minor;
      e_gap  = end_gap;
      e_last = 1'b1;
    end

    pix      = e_acc[ACC_W-1:SFRAC_W];
    pix2     = (pix == PIX_MAX) ? PIX_MAX : pix + CINT_W'(1);
    far_wide = {e_acc[SFRAC_W-1:0], {COVER_W{1'b0}}}
             - {{COVER_W{1'b0}}, e_acc[SFRAC_W-1:0]};
    farb     = far_wide[SFRAC_W+COVER_W-1:SFRAC_W];
    nearb    = COVER_MAX - farb;
    nc_prod  = {{GAP_W{1'b0}}, nearb} * {{COVER_W{1'b0}}, e_gap};
    fc_prod  = {{GAP_W{1'b0}}, farb} * {{COVER_W{1'b0}}, e_gap};
    nc       = nc_prod[COVER_W+CFRAC_W-1:CFRAC_W];
    fc       = fc_prod[COVER_W+CFRAC_W-1:CFRAC_W];

    if (steep) begin
      near_x = pix;
      near_y = e_col;
      far_x  = pix2;
      far_y  = e_col;
    end else begin
      near_x = e_col;
      near_y = pix;
      far_x  = e_col;
      far_y  = pix2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a0          <= in_start_x;
      b0          <= in_start_y;
      a1          <= in_end_x;
      b1          <= in_end_y;
      held_colour <= in_colour;
    end else if (cmd.swap_axes) begin
      steep <= steep_next;
      if (steep_next) begin
        a0 <= b0;
        b0 <= a0;
        a1 <= b1;
        b1 <= a1;
      end
    end else if (cmd.order_ends) begin
      if (a0 > a1) begin
        a0 <= a1;
        b0 <= b1;
        a1 <= a0;
        b1 <= b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvsr <= ord_dx;
      rem  <= {1'b0, ord_dy};
      quo  <= '0;
      neg  <= ord_neg;
    end else if (cmd.div_step) begin
      rem <= {rem_sub[COORD_W-1:0], 1'b0};
      quo <= {quo[COORD_W-2:0], rem_ge};
    end
    if (cmd.div_fin) begin
      if (dvsr == '0) begin
        slope <= '0;
      end else if (neg) begin
        slope <= -$signed({1'b0, quo});
      end else begin
        slope <= $signed({1'b0, quo});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.end_mul) begin
      prod <= prod_next;
      if (cmd.end_sel) begin
        column_last <= rcol;
        end_gap     <= rgap;
      end else begin
        column_now <= rcol;
        first_gap  <= rgap;
      end
    end
    if (cmd.end_add) begin
      if (cmd.end_sel) begin
        end_minor <= end_sat;
      end else begin
        minor_accum <= end_sat;
      end
    end
    if (cmd.emit_first) begin
      minor_accum <= acc_sat;
    end else if (cmd.emit_step) begin
      if (step_inner) begin
        column_now  <= col_inc[CINT_W-1:0];
        minor_accum <= acc_sat;
      end else begin
        column_now <= column_last;
      end
    end
    if (cmd.emit_first || cmd.emit_step) begin
      out_data <= {{OUT_PAD_W{1'b0}}, held_colour, fc, far_y, far_x, nc, near_y, near_x};
      out_last <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.emit_first) begin
      active <= 1'b1;
    end else if (cmd.emit_step && !step_inner) begin
      active <= 1'b0;
    end
  end

  assign stat.active = active;

endmodule

/* design/als_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the line stepper: sequences line setup and the divider and
// owns the request handshakes. Depends on als_pkg.
module als_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_func,
  input  logic               m_tready,
  input  als_pkg::als_stat_t stat,
  output logic               s_tready,
  output logic               m_tvalid,
  output als_pkg::als_cmd_t  cmd
);
  import als_pkg::*;

  als_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid, out_valid_next;
  logic             out_free, emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    emit       = 1'b0;
    out_free   = !out_valid || m_tready;
    case (state)
      ST_IDLE: begin
        s_tready = out_free;
        if (s_tvalid && out_free) begin
          if (s_func == FUNC_START) begin
            cmd.load_in = 1'b1;
            state_next  = ST_SWAP;
          end else if (stat.active) begin
            cmd.emit_step = 1'b1;
            emit          = 1'b1;
          end
        end
      end
      ST_SWAP: begin
        cmd.swap_axes = 1'b1;
        state_next    = ST_ORDER;
      end
      ST_ORDER: begin
        cmd.order_ends = 1'b1;
        state_next     = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        cmd.div_fin = 1'b1;
        state_next  = ST_E1_MUL;
      end
      ST_E1_MUL: begin
        cmd.end_mul = 1'b1;
        state_next  = ST_E1_ADD;
      end
      ST_E1_ADD: begin
        cmd.end_add = 1'b1;
        state_next  = ST_E2_MUL;
      end
      ST_E2_MUL: begin
        cmd.end_mul = 1'b1;
        cmd.end_sel = 1'b1;
        state_next  = ST_E2_ADD;
      end
      ST_E2_ADD: begin
        cmd.end_add = 1'b1;
        cmd.end_sel = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_first = 1'b1;
          emit           = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = emit || (out_valid && !m_tready);
  end

  assign m_tvalid = out_valid;

endmodule

/* design/antialiased_line_stepper.sv */
`timescale 1ns / 1ps
// Anti-aliased line stepper top level: controller plus datapath.
// Depends on als_pkg, als_ctrl and als_datapath.
//
//  Channel | Dir | Carries
//  s_*     | in  | start (endpoints, colour) or step request, kind in s_tuser
//  m_*     | out | one pixel pair with coverages and colour, far end on m_tlast
//
// A step request's pixel pair appears in the output register on the next
// cycle, so steps run at one per cycle when the output is taken. A start
// request goes through axis swap, end ordering, the 17-step serial gradient
// divider, slope and both endpoint multiply-adds before its first pair is
// presented. Reset clears the controller and the line-active flag. A
// stalled output blocks new requests only when the output register is full.
module antialiased_line_stepper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // start_x, start_y, end_x, end_y, line_colour, zero fill
  input  logic [als_pkg::IN_TDATA_W-1:0]     s_tdata,
  // func
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // near_px_x, near_px_y, near_cover, far_px_x, far_px_y, far_cover,
  // pixel_colour, zero fill
  output logic [als_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast
);
  import als_pkg::*;

  als_cmd_t  cmd;
  als_stat_t stat;

  als_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_func   (s_tuser),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  als_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_start_x (s_tdata[COORD_W-1:0]),
    .in_start_y (s_tdata[2*COORD_W-1:COORD_W]),
    .in_end_x   (s_tdata[3*COORD_W-1:2*COORD_W]),
    .in_end_y   (s_tdata[4*COORD_W-1:3*COORD_W]),
    .in_colour  (s_tdata[4*COORD_W+COLOUR_W-1:4*COORD_W]),
    .out_data   (m_tdata),
    .out_last   (m_tlast)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == FUNC_START)) |=> !s_tready)
    else $error("start request did not enter line setup");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == FUNC_STEP) && !stat.active &&
     (!m_tvalid || m_tready)) |=> !m_tvalid)
    else $error("step with no line produced a pixel pair");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !stat.active)
    else $error("line still active while far endpoint pair is pending");

endmodule
